// ===== src/awmt_pkg.sv =====
package awmt_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TRIM_DEPTH = 6;
    localparam int TRIM_SHIFT = 2;
    // 6 samples of 16 bits need 19 bits of running sum
    localparam int SUM_W      = SAMPLE_W + $clog2(TRIM_DEPTH);

    localparam logic MODE_TRIM   = 1'b0;
    localparam logic MODE_MEDIAN = 1'b1;

    // one classified sample on its way from front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                first;  // opens a window
        logic                last;   // completes a window
        logic                mode;
    } item_t;

endpackage

// ===== src/awmt_fifo.sv =====
module awmt_fifo
    import awmt_pkg::*;
#(
    parameter int W = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         do_push;
    logic         do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== src/awmt_front.sv =====
module awmt_front
    import awmt_pkg::*;
#(
    parameter int MEDIAN_DEPTH = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_mode,
    input  logic                push,
    input  logic                full,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                q_push,
    output item_t               q_item
);

    localparam int NEED_MAX = (MEDIAN_DEPTH > TRIM_DEPTH) ? MEDIAN_DEPTH : TRIM_DEPTH;
    localparam int CW       = $clog2(NEED_MAX + 1);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] need;
    logic          mode_reg;
    logic          mode_next;
    logic          accept;
    logic          last;

    assign accept  = push && !full;
    assign need    = (mode_reg == MODE_MEDIAN) ? CW'(MEDIAN_DEPTH) : CW'(TRIM_DEPTH);
    assign cnt_inc = cnt_reg + CW'(1);
    assign last    = (cnt_inc == need);

    assign q_push        = accept;
    assign q_item.sample = sample;
    assign q_item.first  = (cnt_reg == '0);
    assign q_item.last   = last;
    assign q_item.mode   = mode_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        mode_next = mode_reg;
        if (cfg_write)
        begin
            // any mode write drops the partial window
            mode_next = cfg_mode;
            cnt_next  = '0;
        end
        else if (accept)
        begin
            cnt_next = last ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            mode_reg <= MODE_TRIM;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
        end
    end

endmodule

// ===== src/awmt_back.sv =====
module awmt_back
    import awmt_pkg::*;
#(
    parameter int MEDIAN_DEPTH = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  item_t               q_item,
    input  logic                q_empty,
    output logic                q_pop,
    input  logic                res_full,
    output logic                res_push,
    output logic [SAMPLE_W-1:0] res_data
);

    localparam int MID = (MEDIAN_DEPTH - 1) / 2;

    logic [SAMPLE_W-1:0] sort_reg   [MEDIAN_DEPTH];
    logic [SAMPLE_W-1:0] sort_next  [MEDIAN_DEPTH];
    logic [MEDIAN_DEPTH-1:0] valid_reg;
    logic [MEDIAN_DEPTH-1:0] valid_next;
    logic [MEDIAN_DEPTH-1:0] valid_eff;
    logic [MEDIAN_DEPTH-1:0] keep;

    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SAMPLE_W-1:0] min_reg;
    logic [SAMPLE_W-1:0] min_next;
    logic [SAMPLE_W-1:0] max_reg;
    logic [SAMPLE_W-1:0] max_next;
    logic [SUM_W-1:0]    trim_sum;
    logic [SAMPLE_W-1:0] trim_val;
    logic                fire;
    logic [SAMPLE_W-1:0] v;

    assign v     = q_item.sample;
    assign fire  = !q_empty && (!q_item.last || !res_full);
    assign q_pop = fire;

    // insertion into the sorted row: keep entries not above v, shift the rest up
    always_comb
    begin
        valid_eff = q_item.first ? '0 : valid_reg;
        for (int i = 0; i < MEDIAN_DEPTH; i++)
        begin
            keep[i] = valid_eff[i] && !(sort_reg[i] > v);
        end
        sort_next[0]  = keep[0] ? sort_reg[0] : v;
        valid_next[0] = 1'b1;
        for (int i = 1; i < MEDIAN_DEPTH; i++)
        begin
            if (keep[i])
            begin
                sort_next[i] = sort_reg[i];
            end
            else if (keep[i-1])
            begin
                sort_next[i] = v;
            end
            else
            begin
                sort_next[i] = sort_reg[i-1];
            end
            valid_next[i] = valid_eff[i] || valid_eff[i-1];
        end
    end

    // running sum, minimum and maximum for the trimmed mean
    always_comb
    begin
        if (q_item.first)
        begin
            sum_next = SUM_W'(v);
            min_next = v;
            max_next = v;
        end
        else
        begin
            sum_next = sum_reg + SUM_W'(v);
            min_next = (v < min_reg) ? v : min_reg;
            max_next = (v > max_reg) ? v : max_reg;
        end
        trim_sum = sum_next - SUM_W'(min_next) - SUM_W'(max_next);
        trim_val = trim_sum[TRIM_SHIFT +: SAMPLE_W];
    end

    assign res_push = fire && q_item.last;
    assign res_data = (q_item.mode == MODE_MEDIAN) ? sort_next[MID] : trim_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (fire)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            sort_reg <= sort_next;
            sum_reg  <= sum_next;
            min_reg  <= min_next;
            max_reg  <= max_next;
        end
    end

endmodule

// ===== src/adc_window_median_trimmed_mean_unit.sv =====
// channel   dir  handshake            word
// sample    in   push / full          16-bit unsigned converter reading
// filtered  out  empty / pop          16-bit trimmed mean or median
// cfg       in   cfg_valid/cfg_ready  cfg_data: filter mode, 0 trim of 6, 1 median
//
// Rate: one sample word per cycle while full is low; the back retires a word per cycle
// while not stalled, through a combinational insertion sorter and running sum/min/max.
// Result path: a completing word writes its result at the edge it leaves the middle queue;
// the result passes the middle queue and output queue registers before it shows on the ports.
// Reset: rst_n low (async) sets trimmed mean; any mode write (cfg_ready is 1) restarts.
// Stalls: the back holds a completing word on a full output queue; full rises after two.
module adc_window_median_trimmed_mean_unit
    import awmt_pkg::*;
#(
    parameter int MEDIAN_DEPTH = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                push,
    output logic                full,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                empty,
    input  logic                pop,
    output logic [SAMPLE_W-1:0] filtered
);

    localparam int ITEM_W = $bits(item_t);

    item_t               fr_item;
    logic                fr_push;
    logic [ITEM_W-1:0]   mid_dout;
    item_t               mid_item;
    logic                mid_empty;
    logic                mid_pop;
    logic                res_push;
    logic                res_full;
    logic [SAMPLE_W-1:0] res_data;
    logic                cfg_write;

    // take mode writes unconditionally
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // front: count and tag each sample word
    awmt_front #(
        .MEDIAN_DEPTH (MEDIAN_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_mode  (cfg_data),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .q_push    (fr_push),
        .q_item    (fr_item)
    );

    // hold tagged words between front and back
    awmt_fifo #(
        .W (ITEM_W)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fr_push),
        .din   (fr_item),
        .full  (full),
        .pop   (mid_pop),
        .dout  (mid_dout),
        .empty (mid_empty)
    );

    assign mid_item = item_t'(mid_dout);

    // back: sort and accumulate, emit on window completion
    awmt_back #(
        .MEDIAN_DEPTH (MEDIAN_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_item   (mid_item),
        .q_empty  (mid_empty),
        .q_pop    (mid_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_data)
    );

    // hold results until the consumer pops them
    awmt_fifo #(
        .W (SAMPLE_W)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_data),
        .full  (res_full),
        .pop   (pop),
        .dout  (filtered),
        .empty (empty)
    );

    // back never drops a result into a full output queue
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result pushed into full output queue");

    // back only retires words that are present
    assert property (@(posedge clk) disable iff (!rst_n) mid_pop |-> !mid_empty)
        else $error("middle queue popped while empty");

    // a result comes only from a window-completing word
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> (mid_pop && mid_item.last))
        else $error("result without a completing sample");

endmodule
